@@ sv/sfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int MAX_FIND_DEF    = 8;
    localparam int MAX_REPLACE_DEF = 8;
    localparam int PAT_W           = 64;
    localparam int LEN_W           = 4;
    localparam int IDX_W           = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_FIND_PAT = 2'd0,
        REG_FIND_LEN = 2'd1,
        REG_REP_PAT  = 2'd2,
        REG_REP_LEN  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [PAT_W-1:0] find_pat;
        logic [LEN_W-1:0] flen;
        logic [PAT_W-1:0] rep_pat;
        logic [LEN_W-1:0] rlen;
        logic             clr_fill;
    } cfg_t;

    typedef struct packed {
        logic [LEN_W-1:0] cnt;
        logic             data;
        logic             last;
    } load_t;

endpackage

@@ sv/sfr_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_cfg
// Configuration registers with length saturation.
// ----------------------------------------------------------------------------
module sfr_cfg #(
    parameter int MAX_FIND    = sfr_pkg::MAX_FIND_DEF,
    parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sfr_pkg::IDX_W-1:0]  cfg_index,
    input  logic [sfr_pkg::PAT_W-1:0]  cfg_data,
    output sfr_pkg::cfg_t              cfg
);
    import sfr_pkg::*;

    logic [PAT_W-1:0] find_pat_reg;
    logic [LEN_W-1:0] flen_reg;
    logic [PAT_W-1:0] rep_pat_reg;
    logic [LEN_W-1:0] rlen_reg;
    logic [LEN_W-1:0] flen_sat;
    logic [LEN_W-1:0] rlen_sat;

    assign flen_sat = (cfg_data[LEN_W-1:0] > LEN_W'(MAX_FIND)) ? LEN_W'(MAX_FIND)
                                                               : cfg_data[LEN_W-1:0];
    assign rlen_sat = (cfg_data[LEN_W-1:0] > LEN_W'(MAX_REPLACE)) ? LEN_W'(MAX_REPLACE)
                                                                  : cfg_data[LEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            find_pat_reg <= '0;
            flen_reg     <= '0;
            rep_pat_reg  <= '0;
            rlen_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FIND_PAT: find_pat_reg <= cfg_data;
                REG_FIND_LEN: flen_reg     <= flen_sat;
                REG_REP_PAT:  rep_pat_reg  <= cfg_data;
                REG_REP_LEN:  rlen_reg     <= rlen_sat;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        cfg.find_pat = find_pat_reg;
        cfg.flen     = flen_reg;
        cfg.rep_pat  = rep_pat_reg;
        cfg.rlen     = rlen_reg;
        cfg.clr_fill = cfg_we && (cfg_reg_t'(cfg_index) == REG_FIND_LEN);
    end

endmodule

@@ sv/sfr_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_match
// Match window, pattern compare and result selection for one item.
// ----------------------------------------------------------------------------
module sfr_match #(
    parameter int MAX_FIND    = sfr_pkg::MAX_FIND_DEF,
    parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF,
    parameter int BUF_N       = sfr_pkg::MAX_FIND_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  sfr_pkg::cfg_t cfg,
    input  logic          in_fire,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output logic [7:0]    ld_bytes [BUF_N],
    output sfr_pkg::load_t ld
);
    import sfr_pkg::*;

    logic [7:0]       win_reg  [MAX_FIND];
    logic [7:0]       win_next [MAX_FIND];
    logic [7:0]       w_new    [MAX_FIND];
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_next;
    logic [LEN_W-1:0] f;
    logic [LEN_W-1:0] f1;
    logic [LEN_W-1:0] n;
    logic             full;
    logic             hit;
    logic             use_rep;
    logic             marker;

    always_comb
    begin
        f  = (cfg.flen == '0 || fill_reg >= cfg.flen) ? '0 : fill_reg;
        f1 = f + LEN_W'(1);
        for (int k = 0; k < MAX_FIND; k++)
        begin
            w_new[k] = (LEN_W'(k) == f) ? in_byte : win_reg[k];
        end
        full = (cfg.flen != '0) && (f1 == cfg.flen);
        hit  = full;
        for (int k = 0; k < MAX_FIND; k++)
        begin
            if (LEN_W'(k) < cfg.flen && w_new[k] != cfg.find_pat[8*k +: 8])
            begin
                hit = 1'b0;
            end
        end

        win_next  = w_new;
        fill_next = f1;
        use_rep   = 1'b0;
        n         = '0;
        if (cfg.flen == '0)
        begin
            n         = LEN_W'(1);
            fill_next = '0;
        end
        else if (hit)
        begin
            use_rep   = 1'b1;
            n         = cfg.rlen;
            fill_next = '0;
        end
        else if (full)
        begin
            // oldest byte leaves, window slides down
            n         = in_last ? f1 : LEN_W'(1);
            fill_next = f1 - LEN_W'(1);
            for (int k = 0; k < MAX_FIND - 1; k++)
            begin
                win_next[k] = w_new[k+1];
            end
        end
        else
        begin
            n = in_last ? f1 : '0;
        end
        if (in_last)
        begin
            fill_next = '0;
        end

        marker  = in_last && (n == '0);
        ld.cnt  = marker ? LEN_W'(1) : n;
        ld.data = !marker;
        ld.last = in_last;
    end

    for (genvar k = 0; k < BUF_N; k++)
    begin : g_ld
        logic [7:0] rep_b;
        logic [7:0] win_b;
        if (k < MAX_REPLACE)
        begin : g_rep
            assign rep_b = cfg.rep_pat[8*k +: 8];
        end
        else
        begin : g_norep
            assign rep_b = 8'd0;
        end
        if (k < MAX_FIND)
        begin : g_win
            assign win_b = w_new[k];
        end
        else
        begin : g_nowin
            assign win_b = 8'd0;
        end
        if (k == 0)
        begin : g_first
            assign ld_bytes[k] = marker ? 8'd0 : (use_rep ? rep_b : win_b);
        end
        else
        begin : g_rest
            assign ld_bytes[k] = use_rep ? rep_b : win_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cfg.clr_fill)
        begin
            fill_reg <= '0;
        end
        else if (in_fire)
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            win_reg <= win_next;
        end
    end

endmodule

@@ sv/sfr_outbuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_outbuf
// Result buffer: loads all results of an item, drains one per ready cycle.
// ----------------------------------------------------------------------------
module sfr_outbuf #(
    parameter int BUF_N = sfr_pkg::MAX_FIND_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  logic [7:0]     ld_bytes [BUF_N],
    input  sfr_pkg::load_t ld,
    input  logic           result_ready,
    output logic           result_valid,
    output logic           in_ready,
    output logic [7:0]     out_byte,
    output logic           out_valid,
    output logic           out_last
);
    import sfr_pkg::*;

    logic [7:0]       buf_reg  [BUF_N];
    logic [7:0]       buf_next [BUF_N];
    logic [LEN_W-1:0] cnt_reg;
    logic             data_reg;
    logic             last_reg;
    logic             pop;

    assign result_valid = (cnt_reg != '0);
    assign pop          = result_valid && result_ready;
    assign in_ready     = (cnt_reg == '0) || (cnt_reg == LEN_W'(1) && result_ready);
    assign out_byte     = buf_reg[0];
    assign out_valid    = data_reg;
    assign out_last     = last_reg && (cnt_reg == LEN_W'(1));

    always_comb
    begin
        buf_next = buf_reg;
        for (int k = 0; k < BUF_N - 1; k++)
        begin
            buf_next[k] = buf_reg[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            data_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else if (load)
        begin
            cnt_reg  <= ld.cnt;
            data_reg <= ld.data;
            last_reg <= ld.last;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= ld_bytes;
        end
        else if (pop)
        begin
            buf_reg <= buf_next;
        end
    end

endmodule

@@ sv/stream_find_replace.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming substring find-and-replace on a byte stream.
// ----------------------------------------------------------------------------
// Each item is one text byte. While result_ready is high, an item that yields
// at most one result is taken every cycle and the buffer drains one result
// per cycle; one that yields n results (a replacement, or the window flush
// on the last byte) holds the input until they drain, as the next item is
// taken as the last entry leaves. Results appear in the cycle after their
// item. There is no clearing pass after reset. Write configuration only
// while the stream is idle; writing the find length empties the window.
module stream_find_replace #(
    parameter int MAX_FIND    = sfr_pkg::MAX_FIND_DEF,
    parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [sfr_pkg::IDX_W-1:0] cfg_index,
    input  logic [sfr_pkg::PAT_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                in_byte,
    input  logic                      in_last,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [7:0]                out_byte,
    output logic                      out_valid,
    output logic                      out_last
);
    import sfr_pkg::*;

    localparam int BUF_N = (MAX_FIND > MAX_REPLACE) ? MAX_FIND : MAX_REPLACE;

    cfg_t       cfg;
    load_t      ld;
    logic [7:0] ld_bytes [BUF_N];
    logic       in_fire;

    assign in_fire = in_valid && in_ready;

    sfr_cfg #(
        .MAX_FIND    (MAX_FIND),
        .MAX_REPLACE (MAX_REPLACE)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfr_match #(
        .MAX_FIND    (MAX_FIND),
        .MAX_REPLACE (MAX_REPLACE),
        .BUF_N       (BUF_N)
    ) u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_fire  (in_fire),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .ld_bytes (ld_bytes),
        .ld       (ld)
    );

    sfr_outbuf #(
        .BUF_N (BUF_N)
    ) u_outbuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (in_fire),
        .ld_bytes     (ld_bytes),
        .ld           (ld),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .in_ready     (in_ready),
        .out_byte     (out_byte),
        .out_valid    (out_valid),
        .out_last     (out_last)
    );

endmodule

@@ sv/sfr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the stream find-and-replace block.
// ----------------------------------------------------------------------------
module sfr_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_we,
    input logic [sfr_pkg::IDX_W-1:0] cfg_index,
    input logic [sfr_pkg::PAT_W-1:0] cfg_data,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [7:0]                in_byte,
    input logic                      in_last,
    input logic                      result_valid,
    input logic                      result_ready,
    input logic [7:0]                out_byte,
    input logic                      out_valid,
    input logic                      out_last
);

    // stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(out_byte) && $stable(out_valid) && $stable(out_last))
        else $error("stalled result item changed");

    // end marker is always last and carries zero
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !out_valid |-> out_last && out_byte == 8'd0)
        else $error("bad end marker");

    // no new item while a result is stuck
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // input only blocked by pending results
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> result_valid)
        else $error("input blocked with empty buffer");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);
